/* sv/tlb_pkg.sv */
// shared types and constants of the translation buffer
package tlb_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int TAG_BITS  = 20;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        REQ_LOOKUP  = 2'd0,
        REQ_ADD     = 2'd1,
        REQ_REPLACE = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_type_t;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      load_req;
        logic      scan_en;
        logic      scan_first;
        slot_idx_t scan_idx;
        logic      commit;
    } tlb_cmd_t;

endpackage

/* sv/tlb_ctrl.sv */
// controller: sequences accept, slot scan, commit and response
module tlb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output tlb_pkg::tlb_cmd_t cmd
);
    import tlb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESP
    } state_t;

    state_t    state_reg;
    slot_idx_t idx_reg;
    logic      s_ready_reg;
    logic      m_valid_reg;

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    // state, scan index and handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    s_ready_reg <= 1'b1;
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_SCAN;
                        idx_reg     <= '0;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (idx_reg == LAST_SLOT) begin
                        state_reg <= ST_COMMIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_COMMIT: begin
                    state_reg   <= ST_RESP;
                    m_valid_reg <= 1'b1;
                end
                ST_RESP: begin
                    if (m_ready) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b0;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // datapath commands
    always_comb begin
        cmd.load_req   = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.scan_en    = (state_reg == ST_SCAN);
        cmd.scan_first = (state_reg == ST_SCAN) && (idx_reg == '0);
        cmd.scan_idx   = idx_reg;
        cmd.commit     = (state_reg == ST_COMMIT);
    end

endmodule

/* sv/tlb_datapath.sv */
// datapath: slot storage, per-slot scan, update and result registers
module tlb_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tlb_pkg::tlb_cmd_t           cmd,
    input  logic [1:0]                  s_req_type,
    input  logic [19:0]                 s_page_tag,
    input  logic [tlb_pkg::DATA_W-1:0]  s_entry_data,
    output logic                        m_hit,
    output logic [tlb_pkg::DATA_W-1:0]  m_hit_data,
    output logic                        m_add_ok,
    output logic [1:0]                  m_slot_used,
    output logic [tlb_pkg::CNT_W-1:0]   m_hit_total,
    output logic [tlb_pkg::CNT_W-1:0]   m_miss_total
);
    import tlb_pkg::*;

    // request registers
    req_type_t           req_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [DATA_W-1:0]   data_reg;

    // slot storage
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [TAG_BITS-1:0]  slot_tag_reg   [NUM_SLOTS];
    logic [DATA_W-1:0]    slot_data_reg  [NUM_SLOTS];
    logic [CNT_W-1:0]     slot_stamp_reg [NUM_SLOTS];
    logic [CNT_W-1:0]     next_stamp_reg;
    logic [CNT_W-1:0]     hit_cnt_reg;
    logic [CNT_W-1:0]     miss_cnt_reg;

    // scan results
    logic              match_found_reg;
    slot_idx_t         match_idx_reg;
    logic [DATA_W-1:0] match_data_reg;
    logic              empty_found_reg;
    slot_idx_t         empty_idx_reg;
    slot_idx_t         oldest_idx_reg;
    logic [CNT_W-1:0]  oldest_stamp_reg;

    // result registers
    logic              hit_reg;
    logic [DATA_W-1:0] hit_data_reg;
    logic              add_ok_reg;
    logic [1:0]        slot_used_reg;
    logic [CNT_W-1:0]  hit_total_reg;
    logic [CNT_W-1:0]  miss_total_reg;

    // slot read at the scan index
    logic              rd_valid;
    logic              rd_match;
    logic [CNT_W-1:0]  rd_stamp;
    logic [DATA_W-1:0] rd_data;

    // commit decisions
    logic             do_fill;
    slot_idx_t        fill_idx;
    logic             hit_next;
    logic             add_ok_next;
    slot_idx_t        slot_next;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_next;

    always_comb begin
        rd_valid = valid_reg[cmd.scan_idx];
        rd_match = rd_valid && (slot_tag_reg[cmd.scan_idx] == tag_reg);
        rd_stamp = slot_stamp_reg[cmd.scan_idx];
        rd_data  = slot_data_reg[cmd.scan_idx];
    end

    // decide what the request does once the scan is complete
    always_comb begin
        do_fill       = 1'b0;
        fill_idx      = oldest_idx_reg;
        hit_next      = 1'b0;
        add_ok_next   = 1'b0;
        slot_next     = '0;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        case (req_reg)
            REQ_LOOKUP: begin
                hit_next = match_found_reg;
                if (match_found_reg) begin
                    slot_next = match_idx_reg;
                    if (hit_cnt_reg != CNT_MAX) begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                end else if (miss_cnt_reg != CNT_MAX) begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
            end
            REQ_ADD: begin
                if (empty_found_reg) begin
                    do_fill     = 1'b1;
                    fill_idx    = empty_idx_reg;
                    add_ok_next = 1'b1;
                    slot_next   = empty_idx_reg;
                end
            end
            REQ_REPLACE: begin
                do_fill     = 1'b1;
                fill_idx    = oldest_idx_reg;
                add_ok_next = 1'b1;
                slot_next   = oldest_idx_reg;
            end
            default: begin
                do_fill = 1'b0;
            end
        endcase
    end

    // control state: valid bits, stamps and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            next_stamp_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_stamp_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (do_fill) begin
                valid_reg[fill_idx]      <= 1'b1;
                slot_stamp_reg[fill_idx] <= next_stamp_reg;
                next_stamp_reg           <= next_stamp_reg + 1'b1;
            end
        end
    end

    // payload: request capture, slot contents, scan tracking, results
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg  <= req_type_t'(s_req_type);
            tag_reg  <= TAG_BITS'(s_page_tag);
            data_reg <= s_entry_data;
        end

        // one slot per cycle: first match, first empty, smallest stamp
        if (cmd.scan_en) begin
            if (cmd.scan_first) begin
                match_found_reg  <= rd_match;
                match_idx_reg    <= cmd.scan_idx;
                match_data_reg   <= rd_data;
                empty_found_reg  <= !rd_valid;
                empty_idx_reg    <= cmd.scan_idx;
                oldest_idx_reg   <= cmd.scan_idx;
                oldest_stamp_reg <= rd_stamp;
            end else begin
                if (!match_found_reg && rd_match) begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= cmd.scan_idx;
                    match_data_reg  <= rd_data;
                end
                if (!empty_found_reg && !rd_valid) begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= cmd.scan_idx;
                end
                if (rd_stamp < oldest_stamp_reg) begin
                    oldest_idx_reg   <= cmd.scan_idx;
                    oldest_stamp_reg <= rd_stamp;
                end
            end
        end

        if (cmd.commit) begin
            if (do_fill) begin
                slot_tag_reg[fill_idx]  <= tag_reg;
                slot_data_reg[fill_idx] <= data_reg;
            end
            hit_reg        <= hit_next;
            hit_data_reg   <= hit_next ? match_data_reg : '0;
            add_ok_reg     <= add_ok_next;
            slot_used_reg  <= 2'(slot_next);
            hit_total_reg  <= hit_cnt_next;
            miss_total_reg <= miss_cnt_next;
        end
    end

    assign m_hit        = hit_reg;
    assign m_hit_data   = hit_data_reg;
    assign m_add_ok     = add_ok_reg;
    assign m_slot_used  = slot_used_reg;
    assign m_hit_total  = hit_total_reg;
    assign m_miss_total = miss_total_reg;

endmodule

/* sv/tlb_lookup_and_replace_core.sv */
// top level of the fully associative translation buffer
// sequence: accept, then a scan of every slot in turn, a commit state, then the result is held valid
// one transaction at a time; the scan reads one slot per cycle and the result waits for m_ready
// the next transaction is taken in the cycle after the result is accepted
// reset: synchronous active-low aresetn clears valid bits, stamps, counters and handshakes
// slot tags and data are not reset; they are read only once their slot is valid
module tlb_lookup_and_replace_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [19:0]                 s_page_tag,
    input  logic [tlb_pkg::DATA_W-1:0]  s_entry_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [tlb_pkg::DATA_W-1:0]  m_hit_data,
    output logic                        m_add_ok,
    output logic [1:0]                  m_slot_used,
    output logic [tlb_pkg::CNT_W-1:0]   m_hit_total,
    output logic [tlb_pkg::CNT_W-1:0]   m_miss_total
);
    import tlb_pkg::*;

    tlb_cmd_t cmd;

    // sequencing of each transaction
    tlb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // storage and result computation
    tlb_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_req_type   (s_req_type),
        .s_page_tag   (s_page_tag),
        .s_entry_data (s_entry_data),
        .m_hit        (m_hit),
        .m_hit_data   (m_hit_data),
        .m_add_ok     (m_add_ok),
        .m_slot_used  (m_slot_used),
        .m_hit_total  (m_hit_total),
        .m_miss_total (m_miss_total)
    );

endmodule
